FILE: rtl/button_macro_sequencer_core_defines.svh
// Assertion macros for the checker file.
`ifndef BUTTON_MACRO_SEQUENCER_CORE_DEFINES_SVH
`define BUTTON_MACRO_SEQUENCER_CORE_DEFINES_SVH
`define BMS_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define BMS_ASSERT_NEXT(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

FILE: rtl/bms_pkg.sv
package bms_pkg;
  localparam int Buttons = 16;
  localparam int MaxSteps = 8;
  localparam int DelayWidth = 16;
  localparam int BtnW = $clog2(Buttons);
  localparam int StepW = $clog2(MaxSteps);
  localparam int CntW = $clog2(MaxSteps + 1);
  localparam int AddrW = BtnW + StepW;
  localparam int TimeW = 20;
  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam int StepDataW = DelayWidth + 7 + 3;

  typedef enum logic [1:0] {
    REQ_PRESS = 2'd0,
    REQ_TICK = 2'd1,
    REQ_LOAD_STEP = 2'd2,
    REQ_LOAD_HDR = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    KIND_FIRED = 3'd0,
    KIND_STARTED = 3'd1,
    KIND_BUSY = 3'd2,
    KIND_INVALID = 3'd3,
    KIND_STATUS = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_READ, S_WAIT, S_EVAL, S_EMIT, S_STATUS
  } seq_state_e;

  typedef struct packed {
    req_e req_type;
    logic [7:0] btn_code;
    logic [2:0] step_index;
    logic [15:0] step_delay;
    logic [6:0] key_char;
    logic [2:0] modifiers;
    logic [7:0] group_number;
    logic [3:0] step_count;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic [4:0] button_number;
    logic [6:0] key_code;
    logic [2:0] modifier_bits;
    logic [4:0] busy_button;
    logic any_active;
    logic last;
  } res_t;

  function automatic logic [6:0] key_code_of(logic [6:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= 7'h61 && c <= 7'h7a) r = 7'h41 + (c - 7'h61);
    else if (c >= 7'h41 && c <= 7'h5a) r = c;
    else if (c >= 7'h30 && c <= 7'h39) r = c;
    return r;
  endfunction
endpackage

FILE: rtl/bms_ram.sv
module bms_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/bms_front.sv
module bms_front import bms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  cmd_t cmd_i,
  output logic cq_valid_o,
  input  logic cq_ready_i,
  output cmd_t cq_cmd_o
);
  cmd_t buf_q [2];
  logic [1:0] cnt_q;
  logic rd_q, wr_q;
  logic in_fire, out_fire, drop;

  assign full_o = (cnt_q == 2'd2);
  assign in_fire = push_i && !full_o;
  // Words that cause nothing are dropped here.
  assign drop = (cmd_i.req_type != REQ_TICK) &&
                ((cmd_i.btn_code == 8'd0) ||
                 (cmd_i.req_type != REQ_PRESS && cmd_i.btn_code > 8'(Buttons)) ||
                 (cmd_i.req_type == REQ_LOAD_STEP &&
                  {1'b0, cmd_i.step_index} >= 4'(MaxSteps)));
  assign cq_valid_o = (cnt_q != 2'd0);
  assign cq_cmd_o = buf_q[rd_q];
  assign out_fire = cq_valid_o && cq_ready_i;

  always_ff @(posedge clk_i) begin
    if (in_fire && !drop) begin
      buf_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      if (in_fire && !drop) wr_q <= !wr_q;
      if (out_fire) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(in_fire && !drop) - 2'(out_fire);
    end
  end
endmodule

FILE: rtl/bms_back.sv
module bms_back import bms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cq_valid_i,
  output logic cq_ready_o,
  input  cmd_t cq_cmd_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);
  seq_state_e state_q, state_d;
  cmd_t cmd_q, cmd_d;
  logic [7:0] grp_q [Buttons];
  logic [CntW-1:0] steps_q [Buttons];
  logic run_q [Buttons];
  logic [StepW-1:0] cur_q [Buttons];
  logic [TimeW-1:0] acc_q [Buttons];
  logic [TimeW-1:0] ela_q [Buttons];
  logic [BtnW-1:0] order_q [Buttons];
  logic [BtnW:0] act_q, act_d;
  logic [BtnW:0] idx_q, idx_d;
  logic [BtnW:0] keep_q, keep_d;
  logic any_q, any_d;
  res_t out_q, out_d;
  logic ov_q, ov_d;
  logic [BtnW-1:0] b;
  logic [BtnW-1:0] pb;
  logic [StepDataW-1:0] rdata;
  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [TimeW:0] ela1, sum;
  logic fire;
  logic keep_now;

  assign b = order_q[idx_q[BtnW-1:0]];
  assign pb = BtnW'(cmd_q.btn_code - 8'd1);
  assign we = cq_valid_i && cq_ready_o && cq_cmd_i.req_type == REQ_LOAD_STEP;
  assign waddr = {BtnW'(cq_cmd_i.btn_code - 8'd1), cq_cmd_i.step_index[StepW-1:0]};
  assign raddr = {b, cur_q[b]};

  bms_ram #(.Width(StepDataW), .Depth(Buttons * MaxSteps)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr),
    .wdata_i({cq_cmd_i.step_delay, cq_cmd_i.key_char, cq_cmd_i.modifiers}),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign cq_ready_o = (state_q == S_IDLE) && !ov_q;
  assign res_valid_o = ov_q;
  assign res_o = out_q;
  assign ela1 = (ela_q[b] == TimeMax) ? {1'b0, ela_q[b]} : {1'b0, ela_q[b]} + 1'b1;
  assign sum = {1'b0, acc_q[b]} + (TimeW+1)'(rdata[StepDataW-1 -: DelayWidth]);
  assign fire = ela1 > sum;

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    act_d = act_q;
    idx_d = idx_q;
    keep_d = keep_q;
    any_d = any_q;
    out_d = out_q;
    ov_d = ov_q;
    if (ov_q && res_ready_i) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cq_valid_i && !ov_q) begin
          cmd_d = cq_cmd_i;
          idx_d = '0;
          keep_d = '0;
          if (cq_cmd_i.req_type == REQ_PRESS) begin
            if (cq_cmd_i.btn_code > 8'(Buttons)) begin
              out_d = '{KIND_INVALID, 5'd0, 7'd0, 3'd0, 5'd0, 1'b0, 1'b1};
              ov_d = 1'b1;
            end else begin
              state_d = S_SCAN;
            end
          end else if (cq_cmd_i.req_type == REQ_TICK) begin
            state_d = S_READ;
          end
        end
      end
      S_SCAN: begin
        if (idx_q >= act_q) begin
          out_d = '{KIND_STARTED, 5'(cmd_q.btn_code), 7'd0, 3'd0, 5'd0, 1'b0, 1'b1};
          ov_d = 1'b1;
          if (act_q < (BtnW+1)'(Buttons)) act_d = act_q + 1'b1;
          state_d = S_IDLE;
        end else if (b == pb || grp_q[b] == grp_q[pb]) begin
          out_d = '{KIND_BUSY, 5'(cmd_q.btn_code), 7'd0, 3'd0,
                    5'({1'b0, b} + 1'b1), 1'b0, 1'b1};
          ov_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_READ: begin
        if (idx_q >= act_q) begin
          act_d = keep_q;
          any_d = (keep_q != '0);
          state_d = S_STATUS;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: state_d = S_EVAL;
      S_EVAL: begin
        idx_d = idx_q + 1'b1;
        state_d = S_READ;
        if (keep_now) keep_d = keep_q + 1'b1;
        if (run_q[b] && {1'b0, cur_q[b]} < steps_q[b] && fire) begin
          out_d = '{KIND_FIRED, 5'({1'b0, b} + 1'b1), key_code_of(rdata[9:3]),
                    rdata[2:0], 5'd0, 1'b0, 1'b0};
          ov_d = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ov_d) state_d = S_READ;
      end
      S_STATUS: begin
        if (!ov_d) begin
          out_d = '{KIND_STATUS, 5'd0, 7'd0, 3'd0, 5'd0, any_q, 1'b1};
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    keep_now = 1'b0;
    if (state_q == S_EVAL) begin
      if (run_q[b] && {1'b0, cur_q[b]} < steps_q[b]) begin
        keep_now = !(fire && ({1'b0, cur_q[b]} + 1'b1 >= steps_q[b]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q <= '0;
      idx_q <= '0;
      keep_q <= '0;
      any_q <= 1'b0;
      ov_q <= 1'b0;
      for (int i = 0; i < Buttons; i++) begin
        grp_q[i] <= '0;
        steps_q[i] <= '0;
        run_q[i] <= 1'b0;
        cur_q[i] <= '0;
        acc_q[i] <= '0;
        ela_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      act_q <= act_d;
      idx_q <= idx_d;
      any_q <= any_d;
      ov_q <= ov_d;
      keep_q <= keep_d;
      if (state_q == S_IDLE && cq_valid_i && !ov_q &&
          cq_cmd_i.req_type == REQ_LOAD_HDR) begin
        grp_q[BtnW'(cq_cmd_i.btn_code - 8'd1)] <= cq_cmd_i.group_number;
        steps_q[BtnW'(cq_cmd_i.btn_code - 8'd1)] <=
          (cq_cmd_i.step_count > 4'(MaxSteps)) ? CntW'(MaxSteps) : CntW'(cq_cmd_i.step_count);
      end
      if (state_q == S_SCAN && idx_q >= act_q) begin
        cur_q[pb] <= '0;
        acc_q[pb] <= '0;
        ela_q[pb] <= '0;
        run_q[pb] <= (steps_q[pb] != '0);
        if (act_q < (BtnW+1)'(Buttons)) order_q[act_q[BtnW-1:0]] <= pb;
      end
      if (state_q == S_EVAL) begin
        if (run_q[b] && {1'b0, cur_q[b]} < steps_q[b]) begin
          ela_q[b] <= ela1[TimeW-1:0];
          if (fire) begin
            acc_q[b] <= sum[TimeW] ? TimeMax : sum[TimeW-1:0];
            cur_q[b] <= cur_q[b] + 1'b1;
            if ({1'b0, cur_q[b]} + 1'b1 >= steps_q[b]) run_q[b] <= 1'b0;
          end
        end else begin
          run_q[b] <= 1'b0;
        end
        if (keep_now) begin
          order_q[keep_q[BtnW-1:0]] <= b;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end
endmodule

FILE: rtl/button_macro_sequencer_core.sv
// Plays back per-button hotkey sequences. A front queue of two words takes one word per cycle
// until it is full and drops words that are ignored; the back end then runs one word at a
// time, each word being registered in the front queue first. In the back end a load or an
// invalid press is handled in the idle state, a press scans each listed sequence, and a tick
// evaluates each active sequence after a registered step memory read and emits each fired
// step; each result waits until it is popped and stalls the back end meanwhile.
module button_macro_sequencer_core import bms_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] req_type_i,
  input  logic [7:0] btn_code_i,
  input  logic [2:0] step_index_i,
  input  logic [15:0] step_delay_i,
  input  logic [6:0] key_char_i,
  input  logic [2:0] modifiers_i,
  input  logic [7:0] group_number_i,
  input  logic [3:0] step_count_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind_o,
  output logic [4:0] button_number_o,
  output logic [6:0] key_code_o,
  output logic [2:0] modifier_bits_o,
  output logic [4:0] busy_button_o,
  output logic       any_active_o,
  output logic       last_o
);
  cmd_t cmd, cq_cmd;
  res_t res;
  logic cq_valid, cq_ready, res_valid;

  assign cmd = '{req_e'(req_type_i), btn_code_i, step_index_i, step_delay_i,
                 key_char_i, modifiers_i, group_number_i, step_count_i};

  bms_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .cmd_i(cmd),
    .cq_valid_o(cq_valid), .cq_ready_i(cq_ready), .cq_cmd_o(cq_cmd)
  );

  bms_back u_back (
    .clk_i, .rst_ni, .cq_valid_i(cq_valid), .cq_ready_o(cq_ready), .cq_cmd_i(cq_cmd),
    .res_valid_o(res_valid), .res_ready_i(pop), .res_o(res)
  );

  assign empty = !res_valid;
  assign kind_o = res.kind;
  assign button_number_o = res.button_number;
  assign key_code_o = res.key_code;
  assign modifier_bits_o = res.modifier_bits;
  assign busy_button_o = res.busy_button;
  assign any_active_o = res.any_active;
  assign last_o = res.last;
endmodule

FILE: rtl/bms_checker.sv
`include "button_macro_sequencer_core_defines.svh"
module bms_checker import bms_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [2:0] kind_o,
  input logic       any_active_o,
  input logic       last_o
);
  `BMS_ASSERT(a_status_last, clk_i, rst_ni, (!empty && kind_o == KIND_STATUS) |-> last_o)
  `BMS_ASSERT(a_fired_not_last, clk_i, rst_ni, (!empty && kind_o == KIND_FIRED) |-> !last_o)
  `BMS_ASSERT(a_any_status, clk_i, rst_ni, (!empty && any_active_o) |-> kind_o == KIND_STATUS)
  `BMS_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(kind_o))
endmodule

bind button_macro_sequencer_core bms_checker u_bms_checker (
  .clk_i, .rst_ni, .empty, .pop, .kind_o, .any_active_o, .last_o
);
